// ===== rtl/oerb_pkg.sv =====
// Package for the overwriting event ring buffer.
// Field widths, opcodes, command and result types shared by all rtl files.
// No dependencies.
`default_nettype none

package oerb_pkg;

    localparam int COUNT_W       = 32;
    localparam int TYPE_W        = 8;
    localparam int TARGET_W      = 32;
    localparam int PAYLOAD_W     = 64;
    localparam int LIMIT_W       = 7;
    localparam int CAPACITY_DEF  = 256;
    localparam int MAX_BURST_DEF = 64;

    localparam logic OP_EMIT    = 1'b0;
    localparam logic OP_COLLECT = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [TYPE_W-1:0]    ev_type;
        logic [TARGET_W-1:0]  target;
        logic [PAYLOAD_W-1:0] payload;
        logic [LIMIT_W-1:0]   limit;
    } cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0]    ev_type;
        logic [TARGET_W-1:0]  target;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic is_last;
        logic is_empty;
        logic skipped;
    } meta_t;

    typedef struct packed {
        entry_t data;
        meta_t  meta;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/oerb_front.sv =====
// Front end of the event ring buffer: input beat acceptance, enable filter,
// burst limit saturation and a two-entry command queue. Uses oerb_pkg.
`default_nettype none

module oerb_front #(
    parameter int MAX_BURST = oerb_pkg::MAX_BURST_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire                           cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_opcode,
    input  wire [oerb_pkg::TYPE_W-1:0]    s_event_type,
    input  wire [oerb_pkg::TARGET_W-1:0]  s_target_id,
    input  wire [oerb_pkg::PAYLOAD_W-1:0] s_event_payload,
    input  wire [oerb_pkg::LIMIT_W-1:0]   s_max_count,
    output logic                          cmd_valid,
    input  wire                           cmd_ready,
    output oerb_pkg::cmd_t                cmd
);

    localparam int QDEPTH = 2;

    logic                 bus_en_reg;
    oerb_pkg::cmd_t       q_reg [QDEPTH];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    oerb_pkg::cmd_t       in_cmd;
    logic                 push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_en_reg <= 1'b1;
        end else if (cfg_we) begin
            bus_en_reg <= cfg_wdata;
        end
    end

    always_comb begin
        in_cmd.opcode  = s_opcode;
        in_cmd.ev_type = s_event_type;
        in_cmd.target  = s_target_id;
        in_cmd.payload = s_event_payload;
        if (s_max_count > oerb_pkg::LIMIT_W'(MAX_BURST)) begin
            in_cmd.limit = oerb_pkg::LIMIT_W'(MAX_BURST);
        end else begin
            in_cmd.limit = s_max_count;
        end
    end

    assign s_ready   = (count_reg != 2'(QDEPTH));
    assign push      = s_valid && s_ready &&
                       ((s_opcode == oerb_pkg::OP_COLLECT) || bus_en_reg);
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oerb_back.sv =====
// Back end of the event ring buffer: entry memory, write/read counters,
// collect burst sequencer and a four-entry result queue. Uses oerb_pkg.
`default_nettype none

module oerb_back #(
    parameter int CAPACITY = oerb_pkg::CAPACITY_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cmd_valid,
    output logic                           cmd_ready,
    input  oerb_pkg::cmd_t                 cmd,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [oerb_pkg::TYPE_W-1:0]    m_out_type,
    output logic [oerb_pkg::TARGET_W-1:0]  m_out_target,
    output logic [oerb_pkg::PAYLOAD_W-1:0] m_out_payload,
    output logic                           m_is_last,
    output logic                           m_is_empty,
    output logic                           m_skipped_ahead
);

    localparam int AW      = $clog2(CAPACITY);
    localparam int CW      = oerb_pkg::COUNT_W;
    localparam int LW      = oerb_pkg::LIMIT_W;
    localparam int OQ_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         wc_reg, wc_next;
    logic [CW-1:0]         rc_reg, rc_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [LW-1:0]         remain_reg, remain_next;
    logic                  empty_reg, empty_next;
    logic                  skip_reg, skip_next;

    oerb_pkg::entry_t      mem [CAPACITY];
    oerb_pkg::entry_t      rd_data_reg;
    oerb_pkg::meta_t       rd_meta_reg;
    logic                  rd_valid_reg;

    oerb_pkg::result_t     oq_reg [OQ_DEPTH];
    logic [1:0]            oq_wr_reg, oq_rd_reg;
    logic [2:0]            oq_count_reg;
    oerb_pkg::result_t     oq_in;
    logic                  oq_push, oq_pop;

    logic                  take, do_emit, do_collect, issue;
    logic [CW-1:0]         limit32, pending, base;
    logic                  overflow;
    logic [LW-1:0]         n;
    oerb_pkg::entry_t      wr_entry;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign take       = cmd_valid && cmd_ready;
    assign do_emit    = take && (cmd.opcode == oerb_pkg::OP_EMIT);
    assign do_collect = take && (cmd.opcode == oerb_pkg::OP_COLLECT);
    assign issue      = (state_reg == ST_BURST) &&
                        ((oq_count_reg + 3'(rd_valid_reg)) < 3'(OQ_DEPTH));

    always_comb begin
        limit32  = CW'(cmd.limit);
        pending  = wc_reg - rc_reg;
        overflow = pending > CW'(CAPACITY);
        base     = overflow ? (wc_reg - limit32) : rc_reg;
        if (overflow || (pending >= limit32)) begin
            n = cmd.limit;
        end else begin
            n = pending[LW-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        wc_next     = wc_reg;
        rc_next     = rc_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        empty_next  = empty_reg;
        skip_next   = skip_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (do_emit) begin
                    wc_next = wc_reg + CW'(1);
                end else if (do_collect) begin
                    rc_next     = base + CW'(n);
                    ptr_next    = base;
                    remain_next = (n == '0) ? LW'(1) : n;
                    empty_next  = (n == '0);
                    skip_next   = overflow;
                    state_next  = ST_BURST;
                end
            end
            ST_BURST: begin
                if (issue) begin
                    ptr_next    = ptr_reg + CW'(1);
                    remain_next = remain_reg - LW'(1);
                    if (remain_reg == LW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wc_reg       <= '0;
            rc_reg       <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wc_reg       <= wc_next;
            rc_reg       <= rc_next;
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        remain_reg <= remain_next;
        empty_reg  <= empty_next;
        skip_reg   <= skip_next;
    end

    assign wr_entry.ev_type = cmd.ev_type;
    assign wr_entry.target  = cmd.target;
    assign wr_entry.payload = cmd.payload;

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            mem[wc_reg[AW-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg         <= mem[ptr_reg[AW-1:0]];
            rd_meta_reg.is_last  <= (remain_reg == LW'(1));
            rd_meta_reg.is_empty <= empty_reg;
            rd_meta_reg.skipped  <= skip_reg;
        end
    end

    // empty beats carry zero data
    always_comb begin
        oq_in.data = rd_meta_reg.is_empty ? '0 : rd_data_reg;
        oq_in.meta = rd_meta_reg;
    end

    assign oq_push = rd_valid_reg;
    assign m_valid = (oq_count_reg != 3'd0);
    assign oq_pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_reg    <= 2'd0;
            oq_rd_reg    <= 2'd0;
            oq_count_reg <= 3'd0;
        end else begin
            oq_wr_reg    <= oq_wr_reg + 2'(oq_push);
            oq_rd_reg    <= oq_rd_reg + 2'(oq_pop);
            oq_count_reg <= oq_count_reg + 3'(oq_push) - 3'(oq_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (oq_push) begin
            oq_reg[oq_wr_reg] <= oq_in;
        end
    end

    assign m_out_type      = oq_reg[oq_rd_reg].data.ev_type;
    assign m_out_target    = oq_reg[oq_rd_reg].data.target;
    assign m_out_payload   = oq_reg[oq_rd_reg].data.payload;
    assign m_is_last       = oq_reg[oq_rd_reg].meta.is_last;
    assign m_is_empty      = oq_reg[oq_rd_reg].meta.is_empty;
    assign m_skipped_ahead = oq_reg[oq_rd_reg].meta.skipped;

endmodule

`default_nettype wire

// ===== rtl/overwriting_event_ring_buffer_top.sv =====
// Top level of the overwriting event ring buffer.
// Instantiates oerb_front and oerb_back; uses oerb_pkg.
//
// Input beats enter a two-entry command queue at up to one per cycle while it
// has room. The back end stores an emit as it takes it, so emits stream at one
// per cycle while idle. A collect, after setup, issues a read per result beat
// (one beat when empty) on the single read port of the entry memory, whose read
// data is registered; a four-entry result queue decouples the output. CAPACITY
// must be a power of two. Entries hold no reset; no clearing pass after reset.
`default_nettype none

module overwriting_event_ring_buffer_top #(
    parameter int CAPACITY  = oerb_pkg::CAPACITY_DEF,
    parameter int MAX_BURST = oerb_pkg::MAX_BURST_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire                            cfg_wdata,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_opcode,
    input  wire [oerb_pkg::TYPE_W-1:0]     s_event_type,
    input  wire [oerb_pkg::TARGET_W-1:0]   s_target_id,
    input  wire [oerb_pkg::PAYLOAD_W-1:0]  s_event_payload,
    input  wire [oerb_pkg::LIMIT_W-1:0]    s_max_count,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [oerb_pkg::TYPE_W-1:0]    m_out_type,
    output logic [oerb_pkg::TARGET_W-1:0]  m_out_target,
    output logic [oerb_pkg::PAYLOAD_W-1:0] m_out_payload,
    output logic                           m_is_last,
    output logic                           m_is_empty,
    output logic                           m_skipped_ahead
);

    logic           cmd_valid;
    logic           cmd_ready;
    oerb_pkg::cmd_t cmd;

    oerb_front #(
        .MAX_BURST(MAX_BURST)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_event_type    (s_event_type),
        .s_target_id     (s_target_id),
        .s_event_payload (s_event_payload),
        .s_max_count     (s_max_count),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd)
    );

    oerb_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_type      (m_out_type),
        .m_out_target    (m_out_target),
        .m_out_payload   (m_out_payload),
        .m_is_last       (m_is_last),
        .m_is_empty      (m_is_empty),
        .m_skipped_ahead (m_skipped_ahead)
    );

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> m_is_last)
        else $error("empty beat without last mark");

    a_empty_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |->
        ((m_out_type == '0) && (m_out_target == '0) && (m_out_payload == '0)))
        else $error("empty beat with nonzero data");

    a_limit_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && (cmd.opcode == oerb_pkg::OP_COLLECT)) |->
        (cmd.limit <= oerb_pkg::LIMIT_W'(MAX_BURST)))
        else $error("queued collect limit above burst maximum");

endmodule

`default_nettype wire
